/* rtl/counting_semaphore_fifo_waiters_unit_defines.svh */
// Assertion macros shared by the RTL of the semaphore unit.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent check on the unit clock, off while reset is high.
`define CSFW_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("csfw assertion failed");
// Next-cycle implication on the unit clock, off while reset is high.
`define CSFW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csfw assertion failed");
`else
`define CSFW_ASSERT(lbl, prop)
`define CSFW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/csfw_pkg.sv */
package csfw_pkg;

   // Sizes of the bank
   localparam int SEM_COUNT   = 16;
   localparam int THREAD_COUNT = 256;
   localparam int MAX_SIGNALS = 16;

   localparam int SemIdxW    = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
   localparam int ThreadIdxW = $clog2(THREAD_COUNT);
   localparam int ThreadW    = 8;
   localparam int CntW       = 16;
   localparam int LeftW      = $clog2(MAX_SIGNALS + 1);
   localparam int PcW        = 4;

   // Commands
   localparam logic CMD_WAIT   = 1'b0;
   localparam logic CMD_SIGNAL = 1'b1;

   // Result status codes
   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_BLOCKED   = 3'd1,
      ST_NO_WAITER = 3'd2,
      ST_WOKE      = 3'd3,
      ST_INVALID   = 3'd4,
      ST_SATURATED = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   // Datapath action of one microstep
   typedef enum logic [2:0] {
      ACT_NOP,
      ACT_WAIT,
      ACT_SIGNAL,
      ACT_INVALID,
      ACT_EMPTY
   } action_type;

   // Jump condition of one microstep; false falls through to the next step
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_BAD_ID,
      COND_IS_WAIT,
      COND_ZERO_CNT,
      COND_LAST_REP
   } cond_type;

   typedef struct packed {
      action_type       act;
      cond_type         cond;
      logic [PcW-1:0]   target;
   } ucode_type;

   // Microprogram addresses
   localparam logic [PcW-1:0] PC_IDLE    = 4'd0;
   localparam logic [PcW-1:0] PC_CHECK   = 4'd1;
   localparam logic [PcW-1:0] PC_DISP    = 4'd2;
   localparam logic [PcW-1:0] PC_ZCHK    = 4'd3;
   localparam logic [PcW-1:0] PC_FETCH   = 4'd4;
   localparam logic [PcW-1:0] PC_SIG     = 4'd5;
   localparam logic [PcW-1:0] PC_REFETCH = 4'd6;
   localparam logic [PcW-1:0] PC_WAIT    = 4'd7;
   localparam logic [PcW-1:0] PC_INVALID = 4'd8;
   localparam logic [PcW-1:0] PC_EMPTY   = 4'd9;

   // Control store
   function automatic ucode_type ucode_rom(input logic [PcW-1:0] pc);
      ucode_type w;
      case (pc)
         PC_IDLE:    w = '{ACT_NOP,     COND_NO_START, PC_IDLE};
         PC_CHECK:   w = '{ACT_NOP,     COND_BAD_ID,   PC_INVALID};
         PC_DISP:    w = '{ACT_NOP,     COND_IS_WAIT,  PC_WAIT};
         PC_ZCHK:    w = '{ACT_NOP,     COND_ZERO_CNT, PC_EMPTY};
         PC_FETCH:   w = '{ACT_NOP,     COND_NEVER,    PC_IDLE};
         PC_SIG:     w = '{ACT_SIGNAL,  COND_LAST_REP, PC_IDLE};
         PC_REFETCH: w = '{ACT_NOP,     COND_ALWAYS,   PC_SIG};
         PC_WAIT:    w = '{ACT_WAIT,    COND_ALWAYS,   PC_IDLE};
         PC_INVALID: w = '{ACT_INVALID, COND_ALWAYS,   PC_IDLE};
         PC_EMPTY:   w = '{ACT_EMPTY,   COND_ALWAYS,   PC_IDLE};
         default:    w = '{ACT_NOP,     COND_ALWAYS,   PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/counting_semaphore_fifo_waiters_unit.sv */
// Steps: after the start beat the id is checked and the command dispatched; a bad id goes
// to the invalid step, a wait to the wait step, a signal with no repeats to the empty step,
// and any other signal passes a fetch step for the registered read of the wait-link memory before each signal step.
// A signal gives one result per repeat; a new request is taken only when the sequencer is idle.
// Reset: synchronous, clears all semaphore counters and returns the sequencer to idle.
// Results cannot be stalled by the receiver.
`include "counting_semaphore_fifo_waiters_unit_defines.svh"

module counting_semaphore_fifo_waiters_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_cmd,
   input  logic [7:0]                 req_sem_number,
   input  logic [7:0]                 req_thread_id,
   input  logic [4:0]                 req_count,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [7:0]                 rsp_woken_thread,
   output logic signed [15:0]         rsp_counter_after,
   output logic                       rsp_last
);

   localparam int CntW      = csfw_pkg::CntW;
   localparam int ThreadW   = csfw_pkg::ThreadW;
   localparam int ThreadIdxW = csfw_pkg::ThreadIdxW;
   localparam int SemIdxW   = csfw_pkg::SemIdxW;
   localparam int LeftW     = csfw_pkg::LeftW;
   localparam int PcW       = csfw_pkg::PcW;

   localparam logic signed [CntW-1:0] CntMax = {1'b0, {(CntW-1){1'b1}}};
   localparam logic signed [CntW-1:0] CntMin = CntW'(-csfw_pkg::THREAD_COUNT);

   // Sequencer
   logic [PcW-1:0]         pc_ff, pc_in;
   csfw_pkg::ucode_type    uc;
   logic                   cond_true;
   logic                   accept;

   // Latched request
   logic                   cmd_ff;
   logic                   bad_ff;
   logic [SemIdxW-1:0]     sem_ff;
   logic [ThreadW-1:0]     tid_ff;
   logic [LeftW-1:0]       left_ff, left_in;
   logic                   bad_in;

   // Semaphore state
   logic signed [CntW-1:0] cnt_ff  [csfw_pkg::SEM_COUNT];
   logic [ThreadW-1:0]     head_ff [csfw_pkg::SEM_COUNT];
   logic [ThreadW-1:0]     tail_ff [csfw_pkg::SEM_COUNT];
   logic [ThreadW-1:0]     link_mem [csfw_pkg::THREAD_COUNT];
   logic [ThreadW-1:0]     link_rd_ff;

   logic signed [CntW-1:0] cur_cnt;
   logic [ThreadW-1:0]     cur_head;
   logic [ThreadW-1:0]     cur_tail;

   logic                   cnt_we;
   logic signed [CntW-1:0] cnt_wdata;
   logic                   head_we;
   logic [ThreadW-1:0]     head_wdata;
   logic                   tail_we;
   logic                   link_we;
   logic [ThreadIdxW-1:0]  link_waddr;

   // Result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   csfw_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [ThreadW-1:0]     rsp_woken_ff, rsp_woken_in;
   logic signed [CntW-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_last_ff, rsp_last_in;

   assign busy   = (pc_ff != csfw_pkg::PC_IDLE);
   assign accept = start && !busy;
   assign uc     = csfw_pkg::ucode_rom(pc_ff);

   assign cur_cnt  = cnt_ff[sem_ff];
   assign cur_head = head_ff[sem_ff];
   assign cur_tail = tail_ff[sem_ff];

   // Request checks at the start beat; the repeat clamp is in the datapath block below
   always_comb begin
      bad_in = (req_sem_number == 8'd0)
            || (int'(req_sem_number) > csfw_pkg::SEM_COUNT)
            || ((req_cmd == csfw_pkg::CMD_WAIT)
                && (int'(req_thread_id) >= csfw_pkg::THREAD_COUNT));
   end

   // Jump decision and next step
   always_comb begin
      case (uc.cond)
         csfw_pkg::COND_NEVER:    cond_true = 1'b0;
         csfw_pkg::COND_ALWAYS:   cond_true = 1'b1;
         csfw_pkg::COND_NO_START: cond_true = !start;
         csfw_pkg::COND_BAD_ID:   cond_true = bad_ff;
         csfw_pkg::COND_IS_WAIT:  cond_true = (cmd_ff == csfw_pkg::CMD_WAIT);
         csfw_pkg::COND_ZERO_CNT: cond_true = (left_ff == '0);
         csfw_pkg::COND_LAST_REP: cond_true = (left_ff == LeftW'(1));
         default:                 cond_true = 1'b1;
      endcase
      pc_in = cond_true ? uc.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= csfw_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Datapath driven by the current control word
   always_comb begin
      cnt_we        = 1'b0;
      cnt_wdata     = cur_cnt;
      head_we       = 1'b0;
      head_wdata    = tid_ff;
      tail_we       = 1'b0;
      link_we       = 1'b0;
      link_waddr    = cur_tail[ThreadIdxW-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = csfw_pkg::ST_GRANTED;
      rsp_woken_in  = '0;
      rsp_cnt_in    = cur_cnt;
      rsp_last_in   = 1'b1;
      left_in       = left_ff;

      if (accept) begin
         if (int'(req_count) > csfw_pkg::MAX_SIGNALS) begin
            left_in = LeftW'(csfw_pkg::MAX_SIGNALS);
         end else begin
            left_in = LeftW'(req_count);
         end
      end

      case (uc.act)
         csfw_pkg::ACT_WAIT: begin
            rsp_valid_in = 1'b1;
            if (!cur_cnt[CntW-1] && (cur_cnt != '0)) begin
               // free unit: grant
               cnt_we        = 1'b1;
               cnt_wdata     = cur_cnt - 1'b1;
               rsp_cnt_in    = cnt_wdata;
               rsp_status_in = csfw_pkg::ST_GRANTED;
            end else if (cur_cnt <= CntMin) begin
               // queue full
               rsp_status_in = csfw_pkg::ST_SATURATED;
            end else begin
               // append to the queue; an empty queue takes it as head
               if (cur_cnt == '0) begin
                  head_we = 1'b1;
               end else begin
                  link_we = 1'b1;
               end
               tail_we       = 1'b1;
               cnt_we        = 1'b1;
               cnt_wdata     = cur_cnt - 1'b1;
               rsp_cnt_in    = cnt_wdata;
               rsp_status_in = csfw_pkg::ST_BLOCKED;
            end
         end
         csfw_pkg::ACT_SIGNAL: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (left_ff == LeftW'(1));
            left_in      = left_ff - 1'b1;
            if (cur_cnt == CntMax) begin
               rsp_status_in = csfw_pkg::ST_SATURATED;
            end else if (!cur_cnt[CntW-1]) begin
               cnt_we        = 1'b1;
               cnt_wdata     = cur_cnt + 1'b1;
               rsp_cnt_in    = cnt_wdata;
               rsp_status_in = csfw_pkg::ST_NO_WAITER;
            end else begin
               // pop the oldest waiter; its link was fetched last cycle
               cnt_we        = 1'b1;
               cnt_wdata     = cur_cnt + 1'b1;
               head_we       = 1'b1;
               head_wdata    = link_rd_ff;
               rsp_cnt_in    = cnt_wdata;
               rsp_woken_in  = cur_head;
               rsp_status_in = csfw_pkg::ST_WOKE;
            end
         end
         csfw_pkg::ACT_INVALID: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = csfw_pkg::ST_INVALID;
            rsp_cnt_in    = '0;
         end
         csfw_pkg::ACT_EMPTY: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = csfw_pkg::ST_EMPTY;
         end
         default: begin
         end
      endcase
   end

   // Request latch and repeat counter
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         bad_ff <= bad_in;
         sem_ff <= SemIdxW'(req_sem_number - 8'd1);
         tid_ff <= req_thread_id;
      end
      left_ff <= left_in;
   end

   // Counters, reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < csfw_pkg::SEM_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         cnt_ff[sem_ff] <= cnt_wdata;
      end
   end

   // Queue heads and tails
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[sem_ff] <= head_wdata;
      end
      if (tail_we) begin
         tail_ff[sem_ff] <= tid_ff;
      end
   end

   // Wait-link memory: one write port, one registered read at the current head
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= tid_ff;
      end
      link_rd_ff <= link_mem[cur_head[ThreadIdxW-1:0]];
   end

   // Result beat registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_woken_ff  <= rsp_woken_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_woken_thread  = rsp_woken_ff;
   assign rsp_counter_after = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   // Checks
`CSFW_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
`CSFW_ASSERT(a_last_frees, rsp_valid && rsp_last |-> !busy)
`CSFW_ASSERT(a_more_stays_busy, rsp_valid && !rsp_last |-> busy)
`CSFW_ASSERT(a_woken_zero, rsp_valid && rsp_status != csfw_pkg::ST_WOKE |-> rsp_woken_thread == '0)
`CSFW_ASSERT(a_signal_has_repeats, (pc_ff == csfw_pkg::PC_SIG) |-> (left_ff != '0))

endmodule

/* test/tb_counting_semaphore_fifo_waiters_unit.sv */
`timescale 1ns / 100ps

module tb_counting_semaphore_fifo_waiters_unit;

   localparam int CNT_CEILING    = 32767;
   localparam int RANDOM_ITEMS   = 129;
   localparam int STALL_LIMIT    = 2000;
   localparam int MAX_PRINTED    = 200;
   localparam int NUM_DIRECTED   = 21;

   // One directed request; fixed rows carry a single typed-in result
   typedef struct packed {
      logic                 cmd;
      logic [7:0]           sem;
      logic [7:0]           tid;
      logic [4:0]           reps;
      logic                 fixed;
      csfw_pkg::status_type st;
      logic signed [15:0]   cnt;
   } stim_row_type;

   // One result beat
   typedef struct {
      csfw_pkg::status_type st;
      logic [7:0]           woken;
      logic signed [15:0]   cnt;
      logic                 last;
   } sem_beat_type;

   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // empty signal right after reset
      '{csfw_pkg::CMD_SIGNAL, 8'd1,   8'd0,   5'd0,  1'b1, csfw_pkg::ST_EMPTY,    16'sd0},
      // bad semaphore ids, both commands, both ends of the id range
      '{csfw_pkg::CMD_WAIT,   8'd0,   8'd0,   5'd0,  1'b1, csfw_pkg::ST_INVALID,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd0,   8'd0,   5'd16, 1'b1, csfw_pkg::ST_INVALID,  16'sd0},
      '{csfw_pkg::CMD_WAIT,   8'd17,  8'd255, 5'd0,  1'b1, csfw_pkg::ST_INVALID,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd255, 8'd170, 5'd31, 1'b1, csfw_pkg::ST_INVALID,  16'sd0},
      // queue up waiters; count is ignored on a wait
      '{csfw_pkg::CMD_WAIT,   8'd1,   8'd0,   5'd0,  1'b1, csfw_pkg::ST_BLOCKED, -16'sd1},
      '{csfw_pkg::CMD_WAIT,   8'd1,   8'd255, 5'd31, 1'b1, csfw_pkg::ST_BLOCKED, -16'sd2},
      '{csfw_pkg::CMD_WAIT,   8'd1,   8'd90,  5'd0,  1'b1, csfw_pkg::ST_BLOCKED, -16'sd3},
      // same thread queued twice
      '{csfw_pkg::CMD_WAIT,   8'd1,   8'd0,   5'd0,  1'b1, csfw_pkg::ST_BLOCKED, -16'sd4},
      // wake in order, then a clamped count
      '{csfw_pkg::CMD_SIGNAL, 8'd1,   8'd0,   5'd2,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd1,   8'd33,  5'd31, 1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_WAIT,   8'd1,   8'd7,   5'd0,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd16,  8'd0,   5'd1,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_WAIT,   8'd16,  8'd165, 5'd0,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_WAIT,   8'd16,  8'd3,   5'd0,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      // empty signal with a waiter pending
      '{csfw_pkg::CMD_SIGNAL, 8'd16,  8'd0,   5'd0,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd16,  8'd0,   5'd17, 1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_WAIT,   8'd8,   8'd128, 5'd5,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd8,   8'd255, 5'd16, 1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_WAIT,   8'd2,   8'd1,   5'd0,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0},
      '{csfw_pkg::CMD_SIGNAL, 8'd2,   8'd0,   5'd1,  1'b0, csfw_pkg::ST_GRANTED,  16'sd0}
   };

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_cmd = csfw_pkg::CMD_WAIT;
   logic [7:0]         req_sem_number = '0;
   logic [7:0]         req_thread_id = '0;
   logic [4:0]         req_count = '0;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_woken_thread;
   logic signed [15:0] rsp_counter_after;
   logic               rsp_last;

   // typed-in result riding along with the current request
   logic                 row_fixed = 1'b0;
   csfw_pkg::status_type row_st = csfw_pkg::ST_GRANTED;
   logic signed [15:0]   row_cnt = '0;

   // predictor state
   int                 sem_val [csfw_pkg::SEM_COUNT];
   logic [7:0]         q_head [csfw_pkg::SEM_COUNT];
   logic [7:0]         q_tail [csfw_pkg::SEM_COUNT];
   logic [7:0]         q_link [csfw_pkg::THREAD_COUNT];

   sem_beat_type       step_beats [$];
   sem_beat_type       due_beats [$];
   int                 mismatch_count = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;

   counting_semaphore_fifo_waiters_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_sem_number    (req_sem_number),
      .req_thread_id     (req_thread_id),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_woken_thread  (rsp_woken_thread),
      .rsp_counter_after (rsp_counter_after),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void add_beat(input csfw_pkg::status_type st, input logic [7:0] w,
                                    input int c, input logic l);
      sem_beat_type b;
      b.st    = st;
      b.woken = w;
      b.cnt   = c[15:0];
      b.last  = l;
      step_beats.push_back(b);
   endfunction

   // Predict the beats of one request and update the semaphore bank
   function automatic void semaphore_step(input logic cmd, input logic [7:0] sn,
                                          input logic [7:0] tid, input logic [4:0] reps);
      int         s;
      int         c;
      int         n;
      logic [7:0] w;
      step_beats.delete();
      if (sn == 0 || sn > csfw_pkg::SEM_COUNT) begin
         add_beat(csfw_pkg::ST_INVALID, 8'd0, 0, 1'b1);
         return;
      end
      s = sn - 1;
      if (cmd == csfw_pkg::CMD_WAIT) begin
         c = sem_val[s];
         if (int'(tid) >= csfw_pkg::THREAD_COUNT) begin
            add_beat(csfw_pkg::ST_INVALID, 8'd0, 0, 1'b1);
         end else if (c > 0) begin
            sem_val[s] = c - 1;
            add_beat(csfw_pkg::ST_GRANTED, 8'd0, c - 1, 1'b1);
         end else if (c <= -csfw_pkg::THREAD_COUNT) begin
            // queue full: nothing changes
            add_beat(csfw_pkg::ST_SATURATED, 8'd0, c, 1'b1);
         end else begin
            if (c == 0) q_head[s] = tid;
            else q_link[q_tail[s]] = tid;
            q_tail[s] = tid;
            sem_val[s] = c - 1;
            add_beat(csfw_pkg::ST_BLOCKED, 8'd0, c - 1, 1'b1);
         end
         return;
      end
      if (reps == 0) begin
         add_beat(csfw_pkg::ST_EMPTY, 8'd0, sem_val[s], 1'b1);
         return;
      end
      n = (reps > csfw_pkg::MAX_SIGNALS) ? csfw_pkg::MAX_SIGNALS : int'(reps);
      for (int k = 0; k < n; k++) begin
         c = sem_val[s];
         if (c >= CNT_CEILING) begin
            add_beat(csfw_pkg::ST_SATURATED, 8'd0, c, k + 1 == n);
         end else if (c >= 0) begin
            sem_val[s] = c + 1;
            add_beat(csfw_pkg::ST_NO_WAITER, 8'd0, c + 1, k + 1 == n);
         end else begin
            w = q_head[s];
            q_head[s] = q_link[w];
            sem_val[s] = c + 1;
            add_beat(csfw_pkg::ST_WOKE, w, c + 1, k + 1 == n);
         end
      end
   endfunction

   // Check result beats, predict accepted requests, watch for a hang
   always @(posedge clock) begin
      sem_beat_type want;
      sem_beat_type fixed_beat;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat status %0d count %0d",
                                         rsp_status, rsp_counter_after));
            end else begin
               want = due_beats.pop_front();
               if (rsp_status !== want.st)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.st));
               if (rsp_woken_thread !== want.woken)
                  report_mismatch($sformatf("woken_thread got %0d want %0d",
                                            rsp_woken_thread, want.woken));
               if (rsp_counter_after !== want.cnt)
                  report_mismatch($sformatf("counter_after got %0d want %0d",
                                            rsp_counter_after, want.cnt));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last got %0d want %0d", rsp_last, want.last));
            end
         end
         if (start && !busy) begin
            semaphore_step(req_cmd, req_sem_number, req_thread_id, req_count);
            if (row_fixed) begin
               fixed_beat.st    = row_st;
               fixed_beat.woken = 8'd0;
               fixed_beat.cnt   = row_cnt;
               fixed_beat.last  = 1'b1;
               due_beats.push_back(fixed_beat);
            end else begin
               foreach (step_beats[i]) due_beats.push_back(step_beats[i]);
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Gap before the next request: random, with stretches of none
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
      return $urandom_range(0, 18);
   endfunction

   // Present one request at a falling edge and hold it until accepted
   task automatic drive_item(input logic cmd, input logic [7:0] sn, input logic [7:0] tid,
                             input logic [4:0] reps, input logic fixed = 1'b0,
                             input csfw_pkg::status_type st = csfw_pkg::ST_GRANTED,
                             input logic signed [15:0] cnt = '0);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd        <= cmd;
      req_sem_number <= sn;
      req_thread_id  <= tid;
      req_count      <= reps;
      row_fixed      <= fixed;
      row_st         <= st;
      row_cnt        <= cnt;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold off the sender until every expected beat has come
   task automatic drain_all();
      start <= 1'b0;
      @(negedge clock);
      while (due_beats.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic       cmd;
      logic [7:0] sem;
      logic [7:0] tid;
      logic [4:0] reps;
      int         pick;

      foreach (sem_val[i]) begin
         sem_val[i] = 0;
         q_head[i]  = '0;
         q_tail[i]  = '0;
      end
      foreach (q_link[i]) q_link[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++)
         drive_item(DIRECTED[i].cmd, DIRECTED[i].sem, DIRECTED[i].tid, DIRECTED[i].reps,
                    DIRECTED[i].fixed, DIRECTED[i].st, DIRECTED[i].cnt);
      drain_all();

      // random traffic, concentrated on a few semaphores so queues build up
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            sem = $urandom_range(0, 1) ? 8'd0
                                       : 8'($urandom_range(csfw_pkg::SEM_COUNT + 1, 255));
         else if (pick < 75)
            sem = 8'($urandom_range(1, 4));
         else
            sem = 8'($urandom_range(1, csfw_pkg::SEM_COUNT));
         cmd = ($urandom_range(0, 99) < 55) ? csfw_pkg::CMD_WAIT : csfw_pkg::CMD_SIGNAL;
         tid = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 15)      reps = 5'd0;
         else if (pick < 75) reps = 5'($urandom_range(1, 4));
         else if (pick < 93) reps = 5'($urandom_range(5, 16));
         else                reps = 5'($urandom_range(17, 31));
         drive_item(cmd, sem, tid, reps);
         if (i == RANDOM_ITEMS / 2) drain_all();
      end

      drain_all();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/csfw_pkg.sv
rtl/counting_semaphore_fifo_waiters_unit.sv
test/tb_counting_semaphore_fifo_waiters_unit.sv
